// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the cursor canonicaliser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CBCD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CBCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cbcd_pkg.sv =====
// Types, constants and functions of the cursor canonicaliser
package cbcd_pkg;

  localparam int unsigned MAX_DIM_DEFAULT = 512;

  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
  // prime = 2^40 + 0x1b3, so a fold is a shift plus a narrow constant multiply
  localparam int unsigned FNV_SHIFT = 40;
  localparam logic [63:0] FNV_LOW   = FNV_PRIME - (64'd1 << FNV_SHIFT);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned STREAM_W    = 128;
  localparam int unsigned BYTE_CNT_W  = 5;
  localparam logic [BYTE_CNT_W-1:0] HDR_BYTES = BYTE_CNT_W'(16);
  localparam logic [BYTE_CNT_W-1:0] PIX_BYTES = BYTE_CNT_W'(4);

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_PIXEL  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SHAPE  = 2'd1,
    ST_BAD_FORMAT = 2'd2,
    ST_NO_SHAPE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FMT_BGRA = 3'd0,
    FMT_RGBA = 3'd1,
    FMT_ARGB = 3'd2,
    FMT_ABGR = 3'd3,
    FMT_BGRX = 3'd4,
    FMT_RGBX = 3'd5,
    FMT_XBGR = 3'd6,
    FMT_XRGB = 3'd7
  } fmt_t;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_PIXEL  = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_kind_t;

  // header data: {hot_y, hot_x, height, width}; pixel data in [31:0]
  typedef struct packed {
    cmd_kind_t   kind;
    status_t     status;
    logic        last;
    logic [63:0] data;
  } cmd_t;

  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'h0, b};
    return (x << FNV_SHIFT) + (x * FNV_LOW);
  endfunction

  function automatic logic [31:0] swizzle(input fmt_t fmt, input logic [31:0] px);
    logic [7:0] s0, s1, s2, s3, b, g, r, a;
    s0 = px[7:0];
    s1 = px[15:8];
    s2 = px[23:16];
    s3 = px[31:24];
    case (fmt)
      FMT_BGRA: begin b = s0; g = s1; r = s2; a = s3;    end
      FMT_RGBA: begin b = s2; g = s1; r = s0; a = s3;    end
      FMT_ARGB: begin b = s3; g = s2; r = s1; a = s0;    end
      FMT_ABGR: begin b = s1; g = s2; r = s3; a = s0;    end
      FMT_BGRX: begin b = s0; g = s1; r = s2; a = 8'hff; end
      FMT_RGBX: begin b = s2; g = s1; r = s0; a = 8'hff; end
      FMT_XBGR: begin b = s1; g = s2; r = s3; a = 8'hff; end
      default:  begin b = s3; g = s2; r = s1; a = 8'hff; end
    endcase
    // fully transparent pixels carry no colour
    if (a == 8'h00) begin
      b = 8'h00;
      g = 8'h00;
      r = 8'h00;
    end
    return {a, r, g, b};
  endfunction

endpackage

// ===== hdl/cbcd_ifs.sv =====
// Valid/ready channel interfaces for input items and results
interface cbcd_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] shape_width;
  logic [15:0] shape_height;
  logic signed [15:0] hot_x;
  logic signed [15:0] hot_y;
  logic [3:0]  source_format;
  logic [31:0] source_pixel;

  modport source (output valid, opcode, shape_width, shape_height, hot_x, hot_y,
                  source_format, source_pixel, input ready);
  modport sink   (input valid, opcode, shape_width, shape_height, hot_x, hot_y,
                  source_format, source_pixel, output ready);
endinterface

interface cbcd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic [1:0]  status;
  logic        shape_done;
  logic        publish;
  logic [31:0] sequence_number;
  logic [63:0] shape_hash;

  modport source (output valid, out_pixel, status, shape_done, publish,
                  sequence_number, shape_hash, input ready);
  modport sink   (input valid, out_pixel, status, shape_done, publish,
                  sequence_number, shape_hash, output ready);
endinterface

// ===== hdl/cbcd_front.sv =====
// Front end: accepts items, checks headers, tracks the open shape, swizzles pixels
`include "assert_macros.svh"

module cbcd_front #(
  parameter int unsigned MAX_DIM = cbcd_pkg::MAX_DIM_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  cbcd_in_if.sink        in_if,
  input  logic           q_full,
  output logic           q_push,
  output cbcd_pkg::cmd_t q_cmd
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);

  logic                 shape_active_r, shape_active_nxt;
  logic [CNT_W-1:0]     pixels_left_r, pixels_left_nxt;
  cbcd_pkg::fmt_t       fmt_r, fmt_nxt;

  logic                 bad_shape;
  logic [31:0]          area;

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  assign area = in_if.shape_width * in_if.shape_height;

  assign bad_shape = (in_if.shape_width == 16'd0) || (in_if.shape_width > 16'(MAX_DIM)) ||
                     (in_if.shape_height == 16'd0) || (in_if.shape_height > 16'(MAX_DIM)) ||
                     in_if.hot_x[15] || in_if.hot_y[15] ||
                     (16'(in_if.hot_x) >= in_if.shape_width) ||
                     (16'(in_if.hot_y) >= in_if.shape_height);

  always_comb begin
    shape_active_nxt = shape_active_r;
    pixels_left_nxt  = pixels_left_r;
    fmt_nxt          = fmt_r;
    q_cmd.kind       = cbcd_pkg::CMD_REJECT;
    q_cmd.status     = cbcd_pkg::ST_OK;
    q_cmd.last       = 1'b0;
    q_cmd.data       = 64'h0;
    if (in_if.opcode == cbcd_pkg::OP_HEADER) begin
      q_cmd.data = {in_if.hot_y, in_if.hot_x, in_if.shape_height, in_if.shape_width};
      if (q_push) begin
        shape_active_nxt = 1'b0;
        pixels_left_nxt  = '0;
      end
      if (bad_shape) begin
        q_cmd.status = cbcd_pkg::ST_BAD_SHAPE;
      end else if (in_if.source_format[3]) begin
        q_cmd.status = cbcd_pkg::ST_BAD_FORMAT;
      end else begin
        q_cmd.kind = cbcd_pkg::CMD_HEADER;
        if (q_push) begin
          shape_active_nxt = 1'b1;
          pixels_left_nxt  = area[CNT_W-1:0];
          fmt_nxt          = cbcd_pkg::fmt_t'(in_if.source_format[2:0]);
        end
      end
    end else if (!shape_active_r) begin
      q_cmd.status = cbcd_pkg::ST_NO_SHAPE;
    end else begin
      q_cmd.kind = cbcd_pkg::CMD_PIXEL;
      q_cmd.data = {32'h0, cbcd_pkg::swizzle(fmt_r, in_if.source_pixel)};
      q_cmd.last = (pixels_left_r == CNT_W'(1));
      if (q_push) begin
        pixels_left_nxt = pixels_left_r - CNT_W'(1);
        if (pixels_left_r == CNT_W'(1)) begin
          shape_active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_active_r <= 1'b0;
      pixels_left_r  <= '0;
      fmt_r          <= cbcd_pkg::FMT_BGRA;
    end else begin
      shape_active_r <= shape_active_nxt;
      pixels_left_r  <= pixels_left_nxt;
      fmt_r          <= fmt_nxt;
    end
  end

  `CBCD_ASSERT_NOW(a_open_shape_has_pixels, clk, rst_n, shape_active_r,
                   pixels_left_r != '0, "open shape with no pixels left")
  `CBCD_ASSERT_NEXT(a_last_pixel_closes, clk, rst_n,
                    q_push && (q_cmd.kind == cbcd_pkg::CMD_PIXEL) && q_cmd.last,
                    !shape_active_r, "shape still open after its last pixel")

endmodule

// ===== hdl/cbcd_queue.sv =====
// Short command queue between front end and hash back end
`include "assert_macros.svh"

module cbcd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cbcd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output cbcd_pkg::cmd_t head_cmd,
  output logic           empty
);

  cbcd_pkg::cmd_t                  slots_r [cbcd_pkg::QDEPTH];
  logic [cbcd_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [cbcd_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [cbcd_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign full     = (count_r == cbcd_pkg::QCNT_W'(cbcd_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == cbcd_pkg::QPTR_W'(cbcd_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + cbcd_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == cbcd_pkg::QPTR_W'(cbcd_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + cbcd_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + cbcd_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - cbcd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  `CBCD_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !full, "push into full queue")
  `CBCD_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, pop, !empty, "pop from empty queue")

endmodule

// ===== hdl/cbcd_back.sv =====
// Back end: FNV-1a fold one byte a cycle, de-dup check and result register
`include "assert_macros.svh"

module cbcd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  cbcd_pkg::cmd_t q_head,
  output logic           q_pop,
  cbcd_out_if.source     out_if
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FOLD,
    S_FINISH
  } state_t;

  state_t                              state_r, state_nxt;
  cbcd_pkg::cmd_t                      cmd_r, cmd_nxt;
  logic [63:0]                         work_hash_r, work_hash_nxt;
  logic [cbcd_pkg::STREAM_W-1:0]       stream_r, stream_nxt;
  logic [cbcd_pkg::BYTE_CNT_W-1:0]     bytes_left_r, bytes_left_nxt;
  logic [63:0]                         running_hash_r, running_hash_nxt;
  logic [63:0]                         published_hash_r, published_hash_nxt;
  logic [31:0]                         seq_r, seq_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [31:0]                         o_pixel_r, o_pixel_nxt;
  logic [1:0]                          o_status_r, o_status_nxt;
  logic                                o_done_r, o_done_nxt;
  logic                                o_pub_r, o_pub_nxt;
  logic [31:0]                         o_seq_r, o_seq_nxt;
  logic [63:0]                         o_hash_r, o_hash_nxt;

  logic                                slot_free;
  logic [31:0]                         seq_inc;

  assign slot_free = !out_valid_r || out_if.ready;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign seq_inc   = seq_r + 32'd1;

  always_comb begin
    state_nxt          = state_r;
    cmd_nxt            = cmd_r;
    work_hash_nxt      = work_hash_r;
    stream_nxt         = stream_r;
    bytes_left_nxt     = bytes_left_r;
    running_hash_nxt   = running_hash_r;
    published_hash_nxt = published_hash_r;
    seq_nxt            = seq_r;
    out_valid_nxt      = out_valid_r && !out_if.ready;
    o_pixel_nxt        = o_pixel_r;
    o_status_nxt       = o_status_r;
    o_done_nxt         = o_done_r;
    o_pub_nxt          = o_pub_r;
    o_seq_nxt          = o_seq_r;
    o_hash_nxt         = o_hash_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          cmd_nxt = q_head;
          case (q_head.kind)
            cbcd_pkg::CMD_HEADER: begin
              // each header value is a little-endian 32-bit word
              work_hash_nxt  = cbcd_pkg::FNV_BASIS;
              stream_nxt     = {16'h0, q_head.data[63:48], 16'h0, q_head.data[47:32],
                                16'h0, q_head.data[31:16], 16'h0, q_head.data[15:0]};
              bytes_left_nxt = cbcd_pkg::HDR_BYTES;
              state_nxt      = S_FOLD;
            end
            cbcd_pkg::CMD_PIXEL: begin
              work_hash_nxt  = running_hash_r;
              stream_nxt     = {96'h0, q_head.data[31:0]};
              bytes_left_nxt = cbcd_pkg::PIX_BYTES;
              state_nxt      = S_FOLD;
            end
            default: begin
              work_hash_nxt  = running_hash_r;
              bytes_left_nxt = '0;
              state_nxt      = S_FINISH;
            end
          endcase
        end
      end
      S_FOLD: begin
        work_hash_nxt  = cbcd_pkg::fnv_fold(work_hash_r, stream_r[7:0]);
        stream_nxt     = stream_r >> 8;
        bytes_left_nxt = bytes_left_r - cbcd_pkg::BYTE_CNT_W'(1);
        if (bytes_left_r == cbcd_pkg::BYTE_CNT_W'(1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_pixel_nxt   = 32'h0;
          o_status_nxt  = cmd_r.status;
          o_done_nxt    = 1'b0;
          o_pub_nxt     = 1'b0;
          o_seq_nxt     = seq_r;
          o_hash_nxt    = work_hash_r;
          if (cmd_r.kind != cbcd_pkg::CMD_REJECT) begin
            running_hash_nxt = work_hash_r;
          end
          if (cmd_r.kind == cbcd_pkg::CMD_PIXEL) begin
            o_pixel_nxt = cmd_r.data[31:0];
            if (cmd_r.last) begin
              o_done_nxt = 1'b1;
              // a zero published hash means none published yet
              if (!(published_hash_r != 64'h0 && published_hash_r == work_hash_r)) begin
                seq_nxt            = (seq_inc == 32'h0) ? 32'd1 : seq_inc;
                o_seq_nxt          = seq_nxt;
                published_hash_nxt = work_hash_r;
                o_pub_nxt          = 1'b1;
              end
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      running_hash_r   <= 64'h0;
      published_hash_r <= 64'h0;
      seq_r            <= 32'h0;
      out_valid_r      <= 1'b0;
      bytes_left_r     <= '0;
    end else begin
      state_r          <= state_nxt;
      running_hash_r   <= running_hash_nxt;
      published_hash_r <= published_hash_nxt;
      seq_r            <= seq_nxt;
      out_valid_r      <= out_valid_nxt;
      bytes_left_r     <= bytes_left_nxt;
    end
    cmd_r       <= cmd_nxt;
    work_hash_r <= work_hash_nxt;
    stream_r    <= stream_nxt;
    o_pixel_r   <= o_pixel_nxt;
    o_status_r  <= o_status_nxt;
    o_done_r    <= o_done_nxt;
    o_pub_r     <= o_pub_nxt;
    o_seq_r     <= o_seq_nxt;
    o_hash_r    <= o_hash_nxt;
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.out_pixel       = o_pixel_r;
  assign out_if.status          = o_status_r;
  assign out_if.shape_done      = o_done_r;
  assign out_if.publish         = o_pub_r;
  assign out_if.sequence_number = o_seq_r;
  assign out_if.shape_hash      = o_hash_r;

  `CBCD_ASSERT_NOW(a_publish_needs_done, clk, rst_n, out_valid_r && o_pub_r,
                   o_done_r && (o_seq_r != 32'h0), "publish without finished shape")
  `CBCD_ASSERT_NOW(a_fold_has_bytes, clk, rst_n, state_r == S_FOLD,
                   bytes_left_r != '0, "fold state with no bytes left")
  `CBCD_ASSERT_NEXT(a_published_matches, clk, rst_n, out_valid_r && o_pub_r && !out_if.ready,
                    published_hash_r == o_hash_r, "published hash differs from result")

endmodule

// ===== hdl/cursor_bitmap_canonicalize_dedup_core.sv =====
// Cursor bitmap canonicaliser with FNV-1a 64 de-duplication, top level
// Header items open a cursor shape; each pixel item is swizzled to BGRA and
// folded into a running FNV-1a 64 hash, and the last pixel of a shape raises
// publish with a new sequence number when the hash differs from the last one
// published. Every item gives exactly one result. The hash unit folds one byte
// per cycle, which sets the rate: a pixel passes the queue pop, four byte folds
// and the result write; a valid header, sixteen byte folds of size and hotspot;
// a rejected item, pop and result write. A two-entry queue lets the front end
// keep accepting while the hash unit works and a result waits to be taken.
`include "assert_macros.svh"

module cursor_bitmap_canonicalize_dedup_core #(
  parameter int unsigned MAX_DIM = cbcd_pkg::MAX_DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  cbcd_in_if.sink     in_if,
  cbcd_out_if.source  out_if
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  cbcd_pkg::cmd_t q_in_cmd;
  cbcd_pkg::cmd_t q_head_cmd;

  cbcd_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in_cmd)
  );

  cbcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .empty    (q_empty)
  );

  cbcd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head_cmd),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

  `CBCD_ASSERT_NOW(a_accept_only_with_room, clk, rst_n, in_if.valid && in_if.ready,
                   !q_full, "beat accepted while queue full")

endmodule

// ===== verif/cursor_bitmap_canonicalize_dedup_core_test.sv =====
// Self-checking testbench for the cursor bitmap canonicaliser core
module cursor_bitmap_canonicalize_dedup_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbcd_pkg::*;

  localparam int unsigned MAX_DIM      = MAX_DIM_DEFAULT;
  localparam int unsigned ITEM_TARGET  = 1150;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [3:0]  FMT_LAST     = 4'(FMT_XRGB);

  typedef enum int {RX_FREE, RX_PATTERN, RX_RANDOM} rx_mode_t;

  typedef struct {
    opcode_t            op;
    logic [15:0]        width;
    logic [15:0]        height;
    logic signed [15:0] hot_x;
    logic signed [15:0] hot_y;
    logic [3:0]         fmt;
    logic [31:0]        pixel;
  } cursor_item_t;

  typedef struct {
    logic [31:0] pixel;
    status_t     status;
    logic        done;
    logic        publish;
    logic [31:0] seq;
    logic [63:0] hash;
  } cursor_result_t;

  logic clk = 1'b0;
  logic rst_n;

  cbcd_in_if  in_ch ();
  cbcd_out_if out_ch ();

  cursor_bitmap_canonicalize_dedup_core #(.MAX_DIM(MAX_DIM)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] cur_hash      = '0;
  logic [63:0] last_pub_hash = '0;
  logic [31:0] pub_seq       = '0;
  logic [18:0] px_remaining  = '0;
  fmt_t        cur_fmt       = FMT_BGRA;
  bit          shape_open    = 1'b0;

  cursor_result_t pending_results[$];

  int unsigned items_sent, mismatches, idle_cycles;
  int unsigned n_opened, n_rejected, n_stray, n_pixels, n_finished, n_published;
  int unsigned burst_left;
  bit          pace_on = 1'b1;
  rx_mode_t    rx_mode = RX_PATTERN;
  bit          hold_req;

  function automatic logic [63:0] fnv_octet(logic [63:0] h, logic [7:0] b);
    return (h ^ {56'h0, b}) * FNV_PRIME;
  endfunction

  function automatic logic [63:0] fnv_word(logic [63:0] h, logic [31:0] w);
    logic [63:0] acc;
    acc = h;
    for (int i = 0; i < 4; i++) acc = fnv_octet(acc, w[8*i +: 8]);
    return acc;
  endfunction

  function automatic logic [31:0] to_bgra(fmt_t f, logic [31:0] px);
    int bi, gi, ri, ai;
    logic [7:0] alpha;
    logic [7:0] colour [3];
    bi = 0; gi = 1; ri = 2; ai = 3;
    case (f)
      FMT_BGRA, FMT_BGRX: begin
        bi = 0; gi = 1; ri = 2; ai = 3;
      end
      FMT_RGBA, FMT_RGBX: begin
        bi = 2; gi = 1; ri = 0; ai = 3;
      end
      FMT_ARGB, FMT_XRGB: begin
        bi = 3; gi = 2; ri = 1; ai = 0;
      end
      default: begin
        bi = 1; gi = 2; ri = 3; ai = 0;
      end
    endcase
    alpha = (f inside {FMT_BGRX, FMT_RGBX, FMT_XBGR, FMT_XRGB}) ? 8'hff : px[8*ai +: 8];
    colour[0] = px[8*bi +: 8];
    colour[1] = px[8*gi +: 8];
    colour[2] = px[8*ri +: 8];
    if (alpha == 8'h00) return 32'h0;
    return {alpha, colour[2], colour[1], colour[0]};
  endfunction

  // advances the predicted cursor state by one beat and returns its result
  function automatic cursor_result_t cursor_step(cursor_item_t it);
    cursor_result_t r;
    logic [63:0] h;
    r.pixel = '0;
    r.status = ST_OK;
    r.done = 1'b0;
    r.publish = 1'b0;
    if (it.op == OP_HEADER) begin
      shape_open = 1'b0;
      px_remaining = '0;
      if (it.width == 0 || it.width > MAX_DIM || it.height == 0 || it.height > MAX_DIM ||
          it.hot_x < 0 || it.hot_y < 0 ||
          it.hot_x >= it.width || it.hot_y >= it.height) begin
        r.status = ST_BAD_SHAPE;
        n_rejected++;
      end else if (it.fmt > FMT_LAST) begin
        r.status = ST_BAD_FORMAT;
        n_rejected++;
      end else begin
        h = fnv_word(FNV_BASIS, {16'h0, it.width});
        h = fnv_word(h, {16'h0, it.height});
        h = fnv_word(h, {16'h0, it.hot_x});
        h = fnv_word(h, {16'h0, it.hot_y});
        cur_hash = h;
        px_remaining = it.width * it.height;
        cur_fmt = fmt_t'(it.fmt[2:0]);
        shape_open = 1'b1;
        n_opened++;
      end
    end else if (!shape_open) begin
      r.status = ST_NO_SHAPE;
      n_stray++;
    end else begin
      r.pixel = to_bgra(cur_fmt, it.pixel);
      cur_hash = fnv_word(cur_hash, r.pixel);
      n_pixels++;
      if (px_remaining != 0) px_remaining = px_remaining - 1'b1;
      if (px_remaining == 0) begin
        shape_open = 1'b0;
        r.done = 1'b1;
        n_finished++;
        // zero stands for nothing published yet
        if (!(last_pub_hash != 0 && last_pub_hash == cur_hash)) begin
          pub_seq = pub_seq + 1'b1;
          if (pub_seq == 0) pub_seq = 32'd1;
          last_pub_hash = cur_hash;
          r.publish = 1'b1;
          n_published++;
        end
      end
    end
    r.seq = pub_seq;
    r.hash = cur_hash;
    return r;
  endfunction

  function automatic cursor_item_t make_header(logic [15:0] w, logic [15:0] h,
                                               logic signed [15:0] hx, logic signed [15:0] hy,
                                               logic [3:0] f);
    cursor_item_t it;
    it.op = OP_HEADER;
    it.width = w;
    it.height = h;
    it.hot_x = hx;
    it.hot_y = hy;
    it.fmt = f;
    it.pixel = $urandom;
    return it;
  endfunction

  function automatic cursor_item_t make_pixel(logic [31:0] px);
    cursor_item_t it;
    it.op = OP_PIXEL;
    it.width = 16'($urandom);
    it.height = 16'($urandom);
    it.hot_x = 16'($urandom);
    it.hot_y = 16'($urandom);
    it.fmt = 4'($urandom);
    it.pixel = px;
    return it;
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    px = $urandom;
    case ($urandom_range(0, 9))
      0: px = 32'h0;
      1: px = 32'hffff_ffff;
      2, 3: px[8*$urandom_range(0, 3) +: 8] = 8'h00;
      default: ;
    endcase
    return px;
  endfunction

  // offers one beat and holds it until taken; paces bursts when enabled
  task automatic send_item(cursor_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= it.op;
    in_ch.shape_width <= it.width;
    in_ch.shape_height <= it.height;
    in_ch.hot_x <= it.hot_x;
    in_ch.hot_y <= it.hot_y;
    in_ch.source_format <= it.fmt;
    in_ch.source_pixel <= it.pixel;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(cursor_step(it));
    items_sent++;
    if (pace_on) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_pixel_without_shape();
    send_item(make_pixel($urandom));
  endtask

  task automatic test_bad_headers();
    send_item(make_header(16'd0, 16'd1, 16'sd0, 16'sd0, 4'(FMT_BGRA)));
    send_item(make_header(16'hffff, 16'd4, 16'sd0, 16'sd0, 4'(FMT_RGBA)));
    send_item(make_header(16'd4, 16'(MAX_DIM + 1), 16'sd0, 16'sd0, 4'(FMT_ARGB)));
    send_item(make_header(16'd8, 16'd8, 16'sh8000, 16'sd0, 4'(FMT_ABGR)));
    send_item(make_header(16'd4, 16'd4, 16'sd0, 16'sd4, 4'(FMT_BGRX)));
    // shape fault wins over the format fault
    send_item(make_header(16'(MAX_DIM), 16'(MAX_DIM), 16'sh7fff, 16'sd0, 4'hf));
  endtask

  task automatic test_bad_format();
    send_item(make_header(16'(MAX_DIM), 16'(MAX_DIM), 16'sd0, 16'sd0, FMT_LAST + 4'd1));
    send_item(make_pixel(32'hffff_ffff));
  endtask

  // largest shape, left unfinished; the next header drops it
  task automatic test_abandoned_shape();
    send_item(make_header(16'(MAX_DIM), 16'(MAX_DIM), 16'(MAX_DIM - 1), 16'(MAX_DIM - 1),
                          4'(FMT_BGRX)));
    send_item(make_pixel(32'hffff_ffff));
    send_item(make_pixel(32'h0));
  endtask

  task automatic test_all_formats();
    logic [31:0] px;
    int lane;
    for (int f = 0; f <= FMT_LAST; f++) begin
      px = $urandom;
      if (f <= FMT_ABGR) begin
        lane = (f == FMT_BGRA || f == FMT_RGBA) ? 3 : 0;
        px[8*lane +: 8] = 8'h00;
      end
      send_item(make_header(16'd1, 16'd1, 16'sd0, 16'sd0, 4'(f)));
      send_item(make_pixel(px));
    end
  endtask

  // receiver holds off while a full shape is offered back to back
  task automatic test_output_holdoff();
    drain();
    hold_req = 1'b1;
    pace_on = 1'b0;
    send_item(make_header(16'd3, 16'd3, 16'sd1, 16'sd2, 4'(FMT_XRGB)));
    repeat (9) send_item(make_pixel(random_pixel()));
    pace_on = 1'b1;
    drain();
  endtask

  task automatic test_random_shapes();
    cursor_item_t hdr, last_hdr;
    logic [31:0]  px_list[$];
    logic [15:0]  w, h;
    bit           have_last;
    int           roll, pick, npix, stop_at, epoch;
    have_last = 1'b0;
    epoch = -1;
    while (items_sent < ITEM_TARGET) begin
      if (int'(items_sent / 80) != epoch) begin
        epoch = items_sent / 80;
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        pace_on = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_item(make_header(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                              16'sd0, 16'sd0, 4'($urandom_range(8, 15))));
      end else if (roll < 12) begin
        send_item(make_header(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              4'($urandom)));
      end else if (roll < 17) begin
        send_item(make_pixel(random_pixel()));
      end else begin
        if (have_last && roll < 29) begin
          hdr = last_hdr;
        end else begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            w = 16'($urandom_range(17, 64));
            h = 16'd1;
          end else if (pick < 5) begin
            w = 16'($urandom_range(1, 12));
            h = 16'($urandom_range(1, 12));
          end else begin
            w = 16'($urandom_range(1, 4));
            h = 16'($urandom_range(1, 4));
          end
          hdr = make_header(w, h, 16'($urandom_range(0, w - 1)),
                            16'($urandom_range(0, h - 1)), 4'($urandom_range(0, 7)));
          px_list.delete();
          for (int i = 0; i < int'(w) * int'(h); i++) px_list.push_back(random_pixel());
        end
        npix = px_list.size();
        stop_at = npix;
        if ($urandom_range(0, 99) < 8) stop_at = $urandom_range(0, npix - 1);
        send_item(hdr);
        for (int i = 0; i < stop_at; i++) send_item(make_pixel(px_list[i]));
        last_hdr = hdr;
        have_last = 1'b1;
      end
    end
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cursor_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_pixel", want.pixel, out_ch.out_pixel);
        check_field("status", want.status, out_ch.status);
        check_field("shape_done", want.done, out_ch.shape_done);
        check_field("publish", want.publish, out_ch.publish);
        check_field("sequence_number", want.seq, out_ch.sequence_number);
        check_field("shape_hash", want.hash, out_ch.shape_hash);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("cursor_bitmap_canonicalize_dedup_core_test: FAIL");
        $finish;
      end
    end
  end

  // result side: free-running, a rotating stall pattern, or random draws ready three times in four
  initial begin
    int unsigned hold_left, pat_age;
    logic [15:0] stall_pat;
    hold_left = 0;
    pat_age = 0;
    stall_pat = 16'hb5a3;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE: out_ch.ready <= 1'b1;
          RX_PATTERN: begin
            out_ch.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            pat_age++;
            if (pat_age == 64) begin
              pat_age = 0;
              stall_pat = 16'($urandom) | 16'h0101;
            end
          end
          default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_HEADER;
    in_ch.shape_width = '0;
    in_ch.shape_height = '0;
    in_ch.hot_x = '0;
    in_ch.hot_y = '0;
    in_ch.source_format = '0;
    in_ch.source_pixel = '0;
    burst_left = $urandom_range(1, 16);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pixel_without_shape();
    test_bad_headers();
    test_bad_format();
    test_abandoned_shape();
    test_all_formats();
    test_output_holdoff();
    test_random_shapes();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d beats: %0d shapes opened, %0d headers rejected, %0d stray pixels.",
             items_sent, n_opened, n_rejected, n_stray);
    $display("%0d pixels folded, %0d shapes finished, %0d published, %0d suppressed as repeats.",
             n_pixels, n_finished, n_published, n_finished - n_published);
    if (mismatches == 0)
      $display("cursor_bitmap_canonicalize_dedup_core_test: PASS");
    else
      $display("cursor_bitmap_canonicalize_dedup_core_test: FAIL");
    $finish;
  end

endmodule
